// File: rtl/rv32i_execute_unit_top_defines.svh
// assertion macros used by the execute unit top module
`ifndef RV32I_EXECUTE_UNIT_TOP_DEFINES_SVH
`define RV32I_EXECUTE_UNIT_TOP_DEFINES_SVH

// clocked check, masked while reset is held
`define RVEXU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define RVEXU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rvexu_pkg.sv
// shared constants, codes and types of the execute unit
package rvexu_pkg;

    // data memory geometry, byte count is a power of two
    localparam int MEM_BYTES = 1024;
    localparam int NUM_REGS  = 32;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int ROWS      = MEM_BYTES / 4;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int REG_W     = $clog2(NUM_REGS);

    // operation codes
    localparam logic [5:0] F_ADD   = 6'd0;
    localparam logic [5:0] F_SUB   = 6'd1;
    localparam logic [5:0] F_XOR   = 6'd2;
    localparam logic [5:0] F_OR    = 6'd3;
    localparam logic [5:0] F_AND   = 6'd4;
    localparam logic [5:0] F_SLL   = 6'd5;
    localparam logic [5:0] F_SRL   = 6'd6;
    localparam logic [5:0] F_SRA   = 6'd7;
    localparam logic [5:0] F_SLT   = 6'd8;
    localparam logic [5:0] F_SLTU  = 6'd9;
    localparam logic [5:0] F_ADDI  = 6'd10;
    localparam logic [5:0] F_XORI  = 6'd11;
    localparam logic [5:0] F_ORI   = 6'd12;
    localparam logic [5:0] F_ANDI  = 6'd13;
    localparam logic [5:0] F_SLTI  = 6'd14;
    localparam logic [5:0] F_SLTIU = 6'd15;
    localparam logic [5:0] F_JALR  = 6'd16;
    localparam logic [5:0] F_LB    = 6'd17;
    localparam logic [5:0] F_LH    = 6'd18;
    localparam logic [5:0] F_LW    = 6'd19;
    localparam logic [5:0] F_LBU   = 6'd20;
    localparam logic [5:0] F_LHU   = 6'd21;
    localparam logic [5:0] F_SB    = 6'd22;
    localparam logic [5:0] F_SH    = 6'd23;
    localparam logic [5:0] F_SW    = 6'd24;
    localparam logic [5:0] F_BEQ   = 6'd25;
    localparam logic [5:0] F_BNE   = 6'd26;
    localparam logic [5:0] F_BLT   = 6'd27;
    localparam logic [5:0] F_BLTU  = 6'd28;
    localparam logic [5:0] F_BGE   = 6'd29;
    localparam logic [5:0] F_BGEU  = 6'd30;
    localparam logic [5:0] F_LUI   = 6'd31;
    localparam logic [5:0] F_JAL   = 6'd32;

    // access size
    typedef enum logic [1:0] {
        SZ_B,
        SZ_H,
        SZ_W
    } size_t;

    // data memory request from the execute stage
    typedef struct packed {
        logic              rd;
        logic              wr;
        size_t             size;
        logic              sgn;
        logic [ADDR_W-1:0] base;
        logic [31:0]       data;
    } mem_req_t;

    // execute stage result
    typedef struct packed {
        logic [31:0] next_pc;
        logic        taken;
        logic        wr;
        logic [31:0] val;
        logic        is_load;
        mem_req_t    mem;
    } exec_t;

endpackage

// File: rtl/rvexu_regfile.sv
// register file: two registered read ports, one write port, write-first
module rvexu_regfile
    import rvexu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [REG_W-1:0] raddr1,
    input  logic [REG_W-1:0] raddr2,
    output logic [31:0]      rdata1,
    output logic [31:0]      rdata2,
    input  logic             we,
    input  logic [REG_W-1:0] waddr,
    input  logic [31:0]      wdata
);

    logic [31:0]         mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [31:0]         q1_reg;
    logic [31:0]         q2_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic                f1_reg;
    logic                f2_reg;
    logic [31:0]         wd_reg;

    // valid bits stand for the all-zero reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we && waddr != '0)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // storage write and registered reads
    always_ff @(posedge clk)
    begin
        if (we && waddr != '0)
        begin
            mem[waddr] <= wdata;
        end
        q1_reg <= mem[raddr1];
        q2_reg <= mem[raddr2];
        v1_reg <= vld_reg[raddr1];
        v2_reg <= vld_reg[raddr2];
        f1_reg <= we && waddr != '0 && waddr == raddr1;
        f2_reg <= we && waddr != '0 && waddr == raddr2;
        wd_reg <= wdata;
    end

    // same-cycle write bypass, unwritten entries read zero
    assign rdata1 = f1_reg ? wd_reg : (v1_reg ? q1_reg : 32'd0);
    assign rdata2 = f2_reg ? wd_reg : (v2_reg ? q2_reg : 32'd0);

endmodule

// File: rtl/rvexu_dmem.sv
// byte data memory in four lanes, clearing sweep and load formatting
module rvexu_dmem
    import rvexu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output logic        clearing,
    output logic [31:0] load_value
);

    logic             clr_reg;
    logic [ROW_W-1:0] clr_row_reg;
    logic [1:0]       lo;
    logic [ROW_W-1:0] row;
    logic [2:0]       nbytes;
    logic [1:0]       lo_reg;
    size_t            size_reg;
    logic             sgn_reg;
    logic [7:0]       q_reg [4];
    logic [7:0]       lb [4];
    logic [31:0]      word;

    assign lo       = req.base[1:0];
    assign row      = req.base[ADDR_W-1:2];
    assign clearing = clr_reg;

    // byte count of the access
    always_comb
    begin
        case (req.size)
            SZ_B:    nbytes = 3'd1;
            SZ_H:    nbytes = 3'd2;
            SZ_W:    nbytes = 3'd4;
            default: nbytes = 3'd4;
        endcase
    end

    // clearing sweep after reset, one row per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_row_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_W'(ROWS - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // lanes hold bytes whose address has the lane number in its low bits
    for (genvar j = 0; j < 4; j++)
    begin : g_lane
        logic [7:0]       mem [ROWS];
        logic [1:0]       k;
        logic [ROW_W-1:0] lrow;
        logic             lwe;
        logic [31:0]      sh;
        logic [ROW_W-1:0] waddr;
        logic [7:0]       wbyte;
        logic             wen;

        assign k     = 2'(j) - lo;
        assign lrow  = row + ROW_W'(2'(j) < lo);
        assign lwe   = req.wr && ({1'b0, k} < nbytes);
        assign sh    = req.data >> {k, 3'b000};
        assign waddr = clr_reg ? clr_row_reg : lrow;
        assign wbyte = clr_reg ? 8'd0 : sh[7:0];
        assign wen   = clr_reg || lwe;

        always_ff @(posedge clk)
        begin
            if (wen)
            begin
                mem[waddr] <= wbyte;
            end
            if (req.rd)
            begin
                q_reg[j] <= mem[lrow];
            end
        end
    end

    // load attributes travel with the read
    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            lo_reg   <= lo;
            size_reg <= req.size;
            sgn_reg  <= req.sgn;
        end
    end

    // rotate lanes back into access order
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lb[k] = q_reg[2'(lo_reg + 2'(k))];
        end
        word = {lb[3], lb[2], lb[1], lb[0]};
    end

    // size and sign of the loaded value
    always_comb
    begin
        case (size_reg)
            SZ_B:    load_value = {{24{sgn_reg & word[7]}}, word[7:0]};
            SZ_H:    load_value = {{16{sgn_reg & word[15]}}, word[15:0]};
            SZ_W:    load_value = word;
            default: load_value = word;
        endcase
    end

endmodule

// File: rtl/rvexu_alu.sv
// execute logic: immediate extension, alu, compares, branch and address
module rvexu_alu
    import rvexu_pkg::*;
(
    input  logic [5:0]       func,
    input  logic [REG_W-1:0] dest_reg,
    input  logic [31:0]      imm,
    input  logic [4:0]       imm_shift,
    input  logic [31:0]      pc,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output exec_t            res
);

    logic [31:0] imm_l;
    logic [31:0] im;
    logic [31:0] pc4;
    logic [31:0] addr;
    logic        lt_s;
    logic        lt_u;
    logic        lti_s;
    logic        lti_u;
    logic        cond;
    logic        is_br;
    logic        wr;

    // shift pair sign extension
    assign imm_l = imm << imm_shift;
    assign im    = $unsigned($signed(imm_l) >>> imm_shift);
    assign pc4   = pc + 32'd4;
    assign addr  = a + im;
    assign lt_s  = $signed(a) < $signed(b);
    assign lt_u  = a < b;
    assign lti_s = $signed(a) < $signed(im);
    assign lti_u = a < im;

    // operation decode
    always_comb
    begin
        res          = '0;
        res.next_pc  = pc4;
        res.mem.base = addr[ADDR_W-1:0];
        res.mem.data = b;
        res.mem.size = SZ_W;
        wr           = 1'b0;
        cond         = 1'b0;
        is_br        = 1'b0;
        case (func)
            F_ADD:   begin res.val = a + b;                  wr = 1'b1; end
            F_SUB:   begin res.val = a - b;                  wr = 1'b1; end
            F_XOR:   begin res.val = a ^ b;                  wr = 1'b1; end
            F_OR:    begin res.val = a | b;                  wr = 1'b1; end
            F_AND:   begin res.val = a & b;                  wr = 1'b1; end
            F_SLL:   begin res.val = a << b[4:0];            wr = 1'b1; end
            F_SRL:   begin res.val = a >> b[4:0];            wr = 1'b1; end
            F_SRA:   begin res.val = $unsigned($signed(a) >>> b[4:0]); wr = 1'b1; end
            F_SLT:   begin res.val = {31'd0, lt_s};          wr = 1'b1; end
            F_SLTU:  begin res.val = {31'd0, lt_u};          wr = 1'b1; end
            F_ADDI:  begin res.val = addr;                   wr = 1'b1; end
            F_XORI:  begin res.val = a ^ im;                 wr = 1'b1; end
            F_ORI:   begin res.val = a | im;                 wr = 1'b1; end
            F_ANDI:  begin res.val = a & im;                 wr = 1'b1; end
            F_SLTI:  begin res.val = {31'd0, lti_s};         wr = 1'b1; end
            F_SLTIU: begin res.val = {31'd0, lti_u};         wr = 1'b1; end
            F_JALR:
            begin
                res.val     = pc4;
                wr          = 1'b1;
                res.next_pc = {addr[31:1], 1'b0};
                res.taken   = 1'b1;
            end
            F_LB:    begin res.is_load = 1'b1; res.mem.size = SZ_B; res.mem.sgn = 1'b1; wr = 1'b1; end
            F_LH:    begin res.is_load = 1'b1; res.mem.size = SZ_H; res.mem.sgn = 1'b1; wr = 1'b1; end
            F_LW:    begin res.is_load = 1'b1; res.mem.size = SZ_W; wr = 1'b1; end
            F_LBU:   begin res.is_load = 1'b1; res.mem.size = SZ_B; wr = 1'b1; end
            F_LHU:   begin res.is_load = 1'b1; res.mem.size = SZ_H; wr = 1'b1; end
            F_SB:    begin res.mem.wr = 1'b1; res.mem.size = SZ_B; end
            F_SH:    begin res.mem.wr = 1'b1; res.mem.size = SZ_H; end
            F_SW:    begin res.mem.wr = 1'b1; res.mem.size = SZ_W; end
            F_BEQ:   begin is_br = 1'b1; cond = (a == b); end
            F_BNE:   begin is_br = 1'b1; cond = (a != b); end
            F_BLT:   begin is_br = 1'b1; cond = lt_s; end
            F_BLTU:  begin is_br = 1'b1; cond = lt_u; end
            F_BGE:   begin is_br = 1'b1; cond = !lt_s; end
            F_BGEU:  begin is_br = 1'b1; cond = !lt_u; end
            F_LUI:   begin res.val = imm; wr = 1'b1; end
            F_JAL:
            begin
                res.val     = pc4;
                wr          = 1'b1;
                res.next_pc = pc + (im << 1);
                res.taken   = 1'b1;
            end
            default: ;
        endcase
        // taken branch
        if (is_br && cond)
        begin
            res.next_pc = pc + im;
            res.taken   = 1'b1;
        end
        res.mem.rd = res.is_load;
        // x0 is never written
        res.wr = wr && (dest_reg != '0);
        if (!res.wr)
        begin
            res.val = 32'd0;
        end
    end

endmodule

// File: rtl/rv32i_execute_unit_top.sv
// Execute unit: three stages (register read, execute, writeback/result).
// An accepted item moves through the read, execute and writeback registers.
// Throughput: 1 item per cycle while out_ready holds; an item that reads the
// register the item ahead writes waits in execute until that item retires.
// Reset clears registers and pc at once; data memory is swept to zero
// after reset, MEM_BYTES/4 rows (256 at 1024 bytes), no item taken then.
`include "rv32i_execute_unit_top_defines.svh"

module rv32i_execute_unit_top
    import rvexu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  func,
    input  logic [4:0]  dest_reg,
    input  logic [4:0]  src1_reg,
    input  logic [4:0]  src2_reg,
    input  logic [31:0] imm,
    input  logic [4:0]  imm_shift,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_pc,
    output logic        branch_taken,
    output logic        reg_write,
    output logic [4:0]  write_reg,
    output logic [31:0] write_value
);

    // read stage
    logic             d_valid_reg;
    logic [5:0]       d_func_reg;
    logic [4:0]       d_rd_reg;
    logic [4:0]       d_rs1_reg;
    logic [4:0]       d_rs2_reg;
    logic [31:0]      d_imm_reg;
    logic [4:0]       d_sh_reg;
    // execute stage
    logic             e_valid_reg;
    logic [5:0]       e_func_reg;
    logic [4:0]       e_rd_reg;
    logic [4:0]       e_rs1_reg;
    logic [4:0]       e_rs2_reg;
    logic [31:0]      e_imm_reg;
    logic [4:0]       e_sh_reg;
    logic [31:0]      e_a_reg;
    logic [31:0]      e_a_next;
    logic [31:0]      e_b_reg;
    logic [31:0]      e_b_next;
    logic [31:0]      pc_reg;
    // writeback stage
    logic             w_valid_reg;
    logic [31:0]      w_npc_reg;
    logic             w_taken_reg;
    logic             w_wr_reg;
    logic [4:0]       w_rd_reg;
    logic [31:0]      w_val_reg;
    logic             w_load_reg;

    logic             in_fire;
    logic             out_fire;
    logic             w_free;
    logic             hazard;
    logic             e_fire;
    logic             e_free;
    logic             d_move;
    logic             wb_we;
    logic [31:0]      w_value;
    logic             clearing;
    logic [31:0]      ld_value;
    logic [31:0]      rf_rdata1;
    logic [31:0]      rf_rdata2;
    logic [4:0]       rf_raddr1;
    logic [4:0]       rf_raddr2;
    exec_t            ex;
    mem_req_t         mreq;

    // handshake and stall control
    assign out_valid = w_valid_reg;
    assign out_fire  = out_valid && out_ready;
    assign w_free    = !w_valid_reg || out_fire;
    assign hazard    = e_valid_reg && w_valid_reg && w_wr_reg &&
                       (w_rd_reg == e_rs1_reg || w_rd_reg == e_rs2_reg);
    assign e_fire    = e_valid_reg && w_free && !hazard;
    assign e_free    = !e_valid_reg || e_fire;
    assign d_move    = d_valid_reg && e_free;
    assign in_ready  = !clearing && (!d_valid_reg || d_move);
    assign in_fire   = in_valid && in_ready;
    assign wb_we     = out_fire && w_wr_reg;
    assign w_value   = w_load_reg ? ld_value : w_val_reg;

    // read addresses follow the item that holds the read stage next cycle
    assign rf_raddr1 = in_fire ? src1_reg : d_rs1_reg;
    assign rf_raddr2 = in_fire ? src2_reg : d_rs2_reg;

    rvexu_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .raddr1 (rf_raddr1),
        .raddr2 (rf_raddr2),
        .rdata1 (rf_rdata1),
        .rdata2 (rf_rdata2),
        .we     (wb_we),
        .waddr  (w_rd_reg),
        .wdata  (w_value)
    );

    rvexu_alu u_alu (
        .func      (e_func_reg),
        .dest_reg  (e_rd_reg),
        .imm       (e_imm_reg),
        .imm_shift (e_sh_reg),
        .pc        (pc_reg),
        .a         (e_a_reg),
        .b         (e_b_reg),
        .res       (ex)
    );

    // memory access only when the execute stage moves on
    always_comb
    begin
        mreq    = ex.mem;
        mreq.rd = ex.mem.rd && e_fire;
        mreq.wr = ex.mem.wr && e_fire;
    end

    rvexu_dmem u_dmem (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (mreq),
        .clearing   (clearing),
        .load_value (ld_value)
    );

    // operand capture with patch from the retiring writeback
    always_comb
    begin
        e_a_next = e_a_reg;
        e_b_next = e_b_reg;
        if (d_move)
        begin
            e_a_next = (wb_we && w_rd_reg == d_rs1_reg) ? w_value : rf_rdata1;
            e_b_next = (wb_we && w_rd_reg == d_rs2_reg) ? w_value : rf_rdata2;
        end
        else
        begin
            if (wb_we && w_rd_reg == e_rs1_reg)
            begin
                e_a_next = w_value;
            end
            if (wb_we && w_rd_reg == e_rs2_reg)
            begin
                e_b_next = w_value;
            end
        end
    end

    // stage valids and program counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
            pc_reg      <= 32'd0;
        end
        else
        begin
            if (in_fire)
            begin
                d_valid_reg <= 1'b1;
            end
            else if (d_move)
            begin
                d_valid_reg <= 1'b0;
            end
            if (d_move)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end
            if (e_fire)
            begin
                w_valid_reg <= 1'b1;
                pc_reg      <= ex.next_pc;
            end
            else if (out_fire)
            begin
                w_valid_reg <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            d_func_reg <= func;
            d_rd_reg   <= dest_reg;
            d_rs1_reg  <= src1_reg;
            d_rs2_reg  <= src2_reg;
            d_imm_reg  <= imm;
            d_sh_reg   <= imm_shift;
        end
        if (d_move)
        begin
            e_func_reg <= d_func_reg;
            e_rd_reg   <= d_rd_reg;
            e_rs1_reg  <= d_rs1_reg;
            e_rs2_reg  <= d_rs2_reg;
            e_imm_reg  <= d_imm_reg;
            e_sh_reg   <= d_sh_reg;
        end
        e_a_reg <= e_a_next;
        e_b_reg <= e_b_next;
        if (e_fire)
        begin
            w_npc_reg   <= ex.next_pc;
            w_taken_reg <= ex.taken;
            w_wr_reg    <= ex.wr;
            w_rd_reg    <= ex.wr ? e_rd_reg : 5'd0;
            w_val_reg   <= ex.val;
            w_load_reg  <= ex.is_load;
        end
    end

    // result item
    assign next_pc      = w_npc_reg;
    assign branch_taken = w_taken_reg;
    assign reg_write    = w_wr_reg;
    assign write_reg    = w_rd_reg;
    assign write_value  = w_wr_reg ? w_value : 32'd0;

    // checks
    `RVEXU_ASSERT_ALWAYS(a_no_accept_in_clear, clearing |-> !in_ready,
        "item accepted during memory clear")
    `RVEXU_ASSERT(a_hazard_holds_exec, (e_valid_reg && hazard) |=>
        (e_valid_reg && $stable(e_imm_reg) && $stable(e_func_reg)),
        "execute stage lost item while waiting on writeback")
    `RVEXU_ASSERT(a_no_x0_write, (out_valid && reg_write) |-> (write_reg != 5'd0),
        "register write to x0 reported")
    `RVEXU_ASSERT(a_no_hazard_issue, hazard |-> !e_fire,
        "execute issued with stale operand")

endmodule
